// ----- hdl/ests_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ests_pkg
// types and widths shared by the enclosing sphere core and its cells
// ----------------------------------------------------------------------------
package ests_pkg;

   localparam int CW  = 32;          // coordinate width
   localparam int RW  = CW - 1;      // radius width
   localparam int GW  = 62;          // growth width
   localparam int QB  = CW + 1;      // distance, magnitude and quotient width
   localparam int SW  = 2 * QB;      // squared distance and product width
   localparam int RMW = QB + 3;      // square root remainder width

   typedef struct packed {
      logic signed [CW-1:0] first_center_x;
      logic signed [CW-1:0] first_center_y;
      logic signed [CW-1:0] first_center_z;
      logic [RW-1:0]        first_radius;
      logic signed [CW-1:0] second_center_x;
      logic signed [CW-1:0] second_center_y;
      logic signed [CW-1:0] second_center_z;
      logic [RW-1:0]        second_radius;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] merged_center_x;
      logic signed [CW-1:0] merged_center_y;
      logic signed [CW-1:0] merged_center_z;
      logic [RW-1:0]        merged_radius;
      logic [GW-1:0]        growth;
      logic                 one_contains_other;
      logic                 saturated;
   } rsp_type;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [QB-1:0]        mag_type;

   // item context handed down both cell chains
   typedef struct packed {
      coord_type [2:0] c1;
      coord_type [2:0] c2;
      mag_type [2:0]   mag;
      logic [2:0]      neg;
      logic [RW-1:0]   r1;
      logic [RW-1:0]   r2;
      logic            first_big;
      logic            contains;
      logic [QB-1:0]   span;
      logic [QB-1:0]   rad;
   } ctx_type;

   typedef struct packed {
      logic [QB-1:0] rem;
      logic [QB-1:0] lo;
      logic [QB-1:0] q;
   } div_lane_type;

endpackage

// ----- hdl/ests_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ests_sqrt_cell
// one result bit of the floor square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module ests_sqrt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [ests_pkg::QB-1:0]    in_root,
   input  logic [ests_pkg::RMW-1:0]   in_rem,
   input  logic [ests_pkg::SW-1:0]    in_rad,
   input  ests_pkg::ctx_type          in_ctx,
   output logic                       out_valid,
   output logic [ests_pkg::QB-1:0]    out_root,
   output logic [ests_pkg::RMW-1:0]   out_rem,
   output logic [ests_pkg::SW-1:0]    out_rad,
   output ests_pkg::ctx_type          out_ctx
);

   logic                       valid_ff;
   logic [ests_pkg::QB-1:0]    root_ff, root_in;
   logic [ests_pkg::RMW-1:0]   rem_ff, rem_in, rem_t, trial;
   logic [ests_pkg::SW-1:0]    rad_ff;
   ests_pkg::ctx_type          ctx_ff;

   always_comb begin
      rem_t = {in_rem[ests_pkg::RMW-3:0], in_rad[ests_pkg::SW-1 -: 2]};
      trial = {1'b0, in_root, 2'b01};
      if (rem_t >= trial) begin
         rem_in  = rem_t - trial;
         root_in = {in_root[ests_pkg::QB-2:0], 1'b1};
      end else begin
         rem_in  = rem_t;
         root_in = {in_root[ests_pkg::QB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         root_ff <= root_in;
         rem_ff  <= rem_in;
         rad_ff  <= {in_rad[ests_pkg::SW-3:0], 2'b00};
         ctx_ff  <= in_ctx;
      end
   end

   assign out_valid = valid_ff;
   assign out_root  = root_ff;
   assign out_rem   = rem_ff;
   assign out_rad   = rad_ff;
   assign out_ctx   = ctx_ff;

endmodule

// ----- hdl/ests_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ests_div_cell
// one quotient bit of the three per-axis restoring divisions
// ----------------------------------------------------------------------------
module ests_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  ests_pkg::div_lane_type [2:0] in_lane,
   input  ests_pkg::ctx_type           in_ctx,
   output logic                        out_valid,
   output ests_pkg::div_lane_type [2:0] out_lane,
   output ests_pkg::ctx_type           out_ctx
);

   logic                         valid_ff;
   ests_pkg::div_lane_type [2:0] lane_ff, lane_in;
   ests_pkg::ctx_type            ctx_ff;
   logic [ests_pkg::QB:0]        rem_t [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rem_t[a] = {in_lane[a].rem, in_lane[a].lo[ests_pkg::QB-1]};
         lane_in[a].lo = {in_lane[a].lo[ests_pkg::QB-2:0], 1'b0};
         if (rem_t[a] >= {1'b0, in_ctx.span}) begin
            lane_in[a].rem = ests_pkg::QB'(rem_t[a] - {1'b0, in_ctx.span});
            lane_in[a].q   = {in_lane[a].q[ests_pkg::QB-2:0], 1'b1};
         end else begin
            lane_in[a].rem = rem_t[a][ests_pkg::QB-1:0];
            lane_in[a].q   = {in_lane[a].q[ests_pkg::QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         lane_ff <= lane_in;
         ctx_ff  <= in_ctx;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_ctx   = ctx_ff;

endmodule

// ----- hdl/enclosing_sphere_of_two_spheres_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enclosing_sphere_of_two_spheres_core
// smallest sphere around two spheres, with growth and saturation flag
// ----------------------------------------------------------------------------
// throughput: one item per cycle while req_stall is low, set by the square root
// and divider cell rows (one cell per result bit, each a pipeline stage)
// a two-entry output register and skid keep the input open while one result
// waits; the input stalls while the skid holds a second
// reset clears the valid bits only; the data registers are not reset
module enclosing_sphere_of_two_spheres_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ests_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ests_pkg::rsp_type rsp_data
);

   localparam int CW = ests_pkg::CW;
   localparam int RW = ests_pkg::RW;
   localparam int QB = ests_pkg::QB;
   localparam int SW = ests_pkg::SW;
   localparam int GW = ests_pkg::GW;

   logic en;
   logic skid_v_ff;
   assign en = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // stage 1: differences and magnitudes
   logic s1_v_ff;
   ests_pkg::ctx_type s1_ctx_ff, s1_ctx_in;
   logic [RW-1:0] s1_rdiff_ff, s1_rdiff_in;
   logic signed [CW:0] dx [3];
   ests_pkg::coord_type c1_w [3];
   ests_pkg::coord_type c2_w [3];

   always_comb begin
      c1_w[0] = req_data.first_center_x;
      c1_w[1] = req_data.first_center_y;
      c1_w[2] = req_data.first_center_z;
      c2_w[0] = req_data.second_center_x;
      c2_w[1] = req_data.second_center_y;
      c2_w[2] = req_data.second_center_z;
      s1_ctx_in = '0;
      for (int a = 0; a < 3; a++) begin
         dx[a] = $signed({c2_w[a][CW-1], c2_w[a]}) - $signed({c1_w[a][CW-1], c1_w[a]});
         s1_ctx_in.c1[a]  = c1_w[a];
         s1_ctx_in.c2[a]  = c2_w[a];
         s1_ctx_in.neg[a] = dx[a][CW];
         s1_ctx_in.mag[a] = dx[a][CW] ? QB'(-dx[a]) : QB'(dx[a]);
      end
      s1_ctx_in.r1 = req_data.first_radius;
      s1_ctx_in.r2 = req_data.second_radius;
      s1_ctx_in.first_big = req_data.first_radius > req_data.second_radius;
      s1_rdiff_in = s1_ctx_in.first_big ? req_data.first_radius - req_data.second_radius
                                        : req_data.second_radius - req_data.first_radius;
   end

   // stage 2: squares
   logic s2_v_ff;
   ests_pkg::ctx_type s2_ctx_ff;
   logic [SW-1:0] s2_sq_ff [3];
   logic [2*RW-1:0] s2_rd2_ff;

   // stage 3: squared distance and containment test
   logic s3_v_ff;
   ests_pkg::ctx_type s3_ctx_ff, s3_ctx_in;
   logic [SW-1:0] s3_d2_ff, s3_d2_in;

   always_comb begin
      s3_d2_in = s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
      s3_ctx_in = s2_ctx_ff;
      s3_ctx_in.contains = s3_d2_in <= SW'(s2_rd2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         s1_ctx_ff   <= s1_ctx_in;
         s1_rdiff_ff <= s1_rdiff_in;
         s2_ctx_ff   <= s1_ctx_ff;
         for (int a = 0; a < 3; a++) begin
            s2_sq_ff[a] <= s1_ctx_ff.mag[a] * s1_ctx_ff.mag[a];
         end
         s2_rd2_ff <= s1_rdiff_ff * s1_rdiff_ff;
         s3_ctx_ff <= s3_ctx_in;
         s3_d2_ff  <= s3_d2_in;
      end
   end

   // square root cell row
   logic                     sq_v    [QB+1];
   logic [QB-1:0]            sq_root [QB+1];
   logic [ests_pkg::RMW-1:0] sq_rem  [QB+1];
   logic [SW-1:0]            sq_rad  [QB+1];
   ests_pkg::ctx_type        sq_ctx  [QB+1];

   assign sq_v[0]    = s3_v_ff;
   assign sq_root[0] = '0;
   assign sq_rem[0]  = '0;
   assign sq_rad[0]  = s3_d2_ff;
   assign sq_ctx[0]  = s3_ctx_ff;

   for (genvar i = 0; i < QB; i++) begin : g_sqrt
      ests_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[i]),
         .in_root   (sq_root[i]),
         .in_rem    (sq_rem[i]),
         .in_rad    (sq_rad[i]),
         .in_ctx    (sq_ctx[i]),
         .out_valid (sq_v[i+1]),
         .out_root  (sq_root[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_ctx   (sq_ctx[i+1])
      );
   end

   // stage 4: merged radius and growth of the first radius
   logic s4_v_ff;
   ests_pkg::ctx_type s4_ctx_ff, s4_ctx_in;
   logic [QB-1:0] s4_grow_ff, s4_grow_in;
   logic [QB:0]   rsum;

   always_comb begin
      rsum = {1'b0, sq_root[QB]} + (QB+1)'(sq_ctx[QB].r1) + (QB+1)'(sq_ctx[QB].r2);
      s4_ctx_in = sq_ctx[QB];
      s4_ctx_in.span = sq_root[QB];
      s4_ctx_in.rad  = rsum[QB:1];
      s4_grow_in = rsum[QB:1] - QB'(sq_ctx[QB].r1);
   end

   // stage 5: numerators of the center offsets
   logic s5_v_ff;
   ests_pkg::ctx_type s5_ctx_ff;
   logic [SW-1:0] s5_num_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= sq_v[QB];
         s5_v_ff <= s4_v_ff;
      end
      if (en) begin
         s4_ctx_ff  <= s4_ctx_in;
         s4_grow_ff <= s4_grow_in;
         s5_ctx_ff  <= s4_ctx_ff;
         for (int a = 0; a < 3; a++) begin
            s5_num_ff[a] <= s4_ctx_ff.mag[a] * s4_grow_ff;
         end
      end
   end

   // divider cell row
   logic                         dv_v    [QB+1];
   ests_pkg::div_lane_type [2:0] dv_lane [QB+1];
   ests_pkg::ctx_type            dv_ctx  [QB+1];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dv_lane[0][a].rem = s5_num_ff[a][SW-1:QB];
         dv_lane[0][a].lo  = s5_num_ff[a][QB-1:0];
         dv_lane[0][a].q   = '0;
      end
   end
   assign dv_v[0]   = s5_v_ff;
   assign dv_ctx[0] = s5_ctx_ff;

   for (genvar i = 0; i < QB; i++) begin : g_div
      ests_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_v[i]),
         .in_lane   (dv_lane[i]),
         .in_ctx    (dv_ctx[i]),
         .out_valid (dv_v[i+1]),
         .out_lane  (dv_lane[i+1]),
         .out_ctx   (dv_ctx[i+1])
      );
   end

   // stage 6: center, radius select and clamp
   localparam logic signed [CW+2:0] CMAX = {4'b0000, {(CW-1){1'b1}}};
   localparam logic signed [CW+2:0] CMIN = {4'b1111, {(CW-1){1'b0}}};
   localparam logic [QB-1:0]        RMAX = {2'b00, {RW{1'b1}}};

   logic s6_v_ff;
   ests_pkg::coord_type s6_c_ff [3];
   ests_pkg::coord_type s6_c_in [3];
   logic [RW-1:0] s6_r_ff, s6_r_in, s6_r1_ff;
   logic s6_cont_ff, s6_sat_ff, s6_sat_in;
   logic signed [CW+2:0] off [3];
   logic signed [CW+2:0] cm  [3];

   always_comb begin
      ests_pkg::ctx_type cx;
      cx = dv_ctx[QB];
      s6_sat_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         off[a] = $signed({2'b00, dv_lane[QB][a].q});
         if (cx.neg[a]) begin
            off[a] = -off[a];
         end
         cm[a] = $signed({{3{cx.c1[a][CW-1]}}, cx.c1[a]}) + off[a];
         if (cx.contains) begin
            s6_c_in[a] = cx.first_big ? cx.c1[a] : cx.c2[a];
         end else if (cm[a] > CMAX) begin
            s6_c_in[a] = CMAX[CW-1:0];
            s6_sat_in  = 1'b1;
         end else if (cm[a] < CMIN) begin
            s6_c_in[a] = CMIN[CW-1:0];
            s6_sat_in  = 1'b1;
         end else begin
            s6_c_in[a] = cm[a][CW-1:0];
         end
      end
      if (cx.contains) begin
         s6_r_in = cx.first_big ? cx.r1 : cx.r2;
      end else if (cx.rad > RMAX) begin
         s6_r_in   = RMAX[RW-1:0];
         s6_sat_in = 1'b1;
      end else begin
         s6_r_in = cx.rad[RW-1:0];
      end
   end

   // stage 7: radius squares
   logic s7_v_ff;
   ests_pkg::coord_type s7_c_ff [3];
   logic [RW-1:0] s7_r_ff;
   logic [2*RW-1:0] s7_p1_ff, s7_p0_ff;
   logic s7_cont_ff, s7_sat_ff;

   // stage 8: final result
   logic fin_v_ff;
   ests_pkg::rsp_type fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         fin_v_ff <= 1'b0;
      end else if (en) begin
         s6_v_ff  <= dv_v[QB];
         s7_v_ff  <= s6_v_ff;
         fin_v_ff <= s7_v_ff;
      end
      if (en) begin
         s6_c_ff    <= s6_c_in;
         s6_r_ff    <= s6_r_in;
         s6_r1_ff   <= dv_ctx[QB].r1;
         s6_cont_ff <= dv_ctx[QB].contains;
         s6_sat_ff  <= s6_sat_in;
         s7_c_ff    <= s6_c_ff;
         s7_r_ff    <= s6_r_ff;
         s7_p1_ff   <= s6_r_ff * s6_r_ff;
         s7_p0_ff   <= s6_r1_ff * s6_r1_ff;
         s7_cont_ff <= s6_cont_ff;
         s7_sat_ff  <= s6_sat_ff;
         fin_ff.merged_center_x    <= s7_c_ff[0];
         fin_ff.merged_center_y    <= s7_c_ff[1];
         fin_ff.merged_center_z    <= s7_c_ff[2];
         fin_ff.merged_radius      <= s7_r_ff;
         fin_ff.growth             <= GW'(s7_p1_ff - s7_p0_ff);
         fin_ff.one_contains_other <= s7_cont_ff;
         fin_ff.saturated          <= s7_sat_ff;
      end
   end

   // output register and skid
   logic rsp_v_ff;
   ests_pkg::rsp_type rsp_ff, skid_ff;
   logic rsp_free;
   assign rsp_free = !rsp_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_free) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (rsp_free) begin
         rsp_v_ff <= fin_v_ff;
      end else if (fin_v_ff) begin
         skid_v_ff <= 1'b1;
      end
      if (skid_v_ff) begin
         if (rsp_free) begin
            rsp_ff <= skid_ff;
         end
      end else if (rsp_free) begin
         rsp_ff <= fin_ff;
      end else begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule
